// File: design/mlf_pkg.sv
package mlf_pkg;

   localparam int LINE_W = 8;
   localparam int FIFO_DEPTH = 4;

   localparam logic [1:0] FUNC_PIXEL = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [7:0] CMD_WR  = 8'h80;
   localparam logic [7:0] CMD_VC  = 8'h40;
   localparam logic [7:0] CMD_CLR = 8'h20;
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [6:0] LPT_RESET = 7'd17;

   // byte slots of one request, emitted low index first
   localparam int SLOT_CMD   = 0;
   localparam int SLOT_ADDR  = 1;
   localparam int SLOT_PIX   = 2;
   localparam int SLOT_DUMMY = 3;
   localparam int SLOT_END   = 4;
   localparam int SLOT_REJ   = 5;
   localparam int SLOT_N     = 6;

   typedef struct packed {
      logic [SLOT_N-1:0] slots;
      logic [7:0]        cmd_byte;
      logic [7:0]        addr_byte;
      logic [7:0]        pix_byte;
   } mlf_desc_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

// File: design/mlf_if.sv
interface mlf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [6:0] first_line;
   logic [6:0] line_count;
   logic [7:0] pixel_byte;
   modport source (output valid, func, first_line, line_count, pixel_byte, input ready);
   modport sink (input valid, func, first_line, line_count, pixel_byte, output ready);
endinterface

interface mlf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_transaction;
   logic       refused;
   modport source (output valid, out_byte, end_of_transaction, refused, input ready);
   modport sink (input valid, out_byte, end_of_transaction, refused, output ready);
endinterface

interface mlf_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: design/mlf_fifo.sv
module mlf_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mlf_pkg::mlf_desc_type push_data,
   output logic                  full,
   input  logic                  pop,
   output mlf_pkg::mlf_desc_type pop_data,
   output logic                  empty
);
   import mlf_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   mlf_desc_type mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue pop while empty");

endmodule

// File: design/mlf_front.sv
module mlf_front #(
   parameter int PANEL_LINES,
   parameter int LINE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   mlf_req_if.sink               req_chan,
   mlf_csr_if.sink               csr_chan,
   output logic                  push,
   output mlf_pkg::mlf_desc_type push_data,
   input  logic                  full
);
   import mlf_pkg::*;

   localparam int BYTE_W = $clog2(LINE_BYTES + 1);
   localparam logic [8:0] PANEL_MAX = 9'(PANEL_LINES);

   logic              vcom_ff, vcom_in;
   logic              active_ff, active_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [6:0]        rem_ff, rem_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [6:0]        lit_ff, lit_in;
   logic [6:0]        lpt_ff;

   logic              accept, start, bad_range, line_done, ends_txn, emits;
   logic              eff_vcom;
   logic [LINE_W-1:0] eff_line, line_inc;
   logic [6:0]        eff_rem, rem_dec, eff_lit, lit_inc, lpt_eff;
   logic [BYTE_W-1:0] eff_byte;
   logic [8:0]        range_end;
   mlf_desc_type      desc;

   assign req_chan.ready = !full;
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && !full;

   always_comb begin
      lpt_eff   = (lpt_ff == '0) ? 7'd1 : lpt_ff;
      start     = !active_ff;
      range_end = 9'(req_chan.first_line) + 9'(req_chan.line_count);
      bad_range = (req_chan.line_count == '0) || (range_end > PANEL_MAX);
      eff_vcom  = start ? !vcom_ff : vcom_ff;
      eff_line  = start ? LINE_W'(req_chan.first_line) : line_ff;
      eff_rem   = start ? req_chan.line_count : rem_ff;
      eff_lit   = start ? '0 : lit_ff;
      eff_byte  = start ? '0 : byte_ff;
      line_inc  = eff_line + 1'b1;
      rem_dec   = eff_rem - 1'b1;
      lit_inc   = eff_lit + 1'b1;
      line_done = (eff_byte == BYTE_W'(LINE_BYTES - 1));
      ends_txn  = line_done && ((lit_inc >= lpt_eff) || (rem_dec == '0));

      vcom_in   = vcom_ff;
      active_in = active_ff;
      line_in   = line_ff;
      rem_in    = rem_ff;
      byte_in   = byte_ff;
      lit_in    = lit_ff;
      emits     = 1'b0;
      desc.slots     = '0;
      desc.cmd_byte  = BYTE_ZERO;
      desc.addr_byte = rev8(line_inc);
      desc.pix_byte  = req_chan.pixel_byte;

      case (req_chan.func) inside
         FUNC_PIXEL: begin
            emits = 1'b1;
            if (start && bad_range) begin
               desc.slots[SLOT_REJ] = 1'b1;
            end else begin
               desc.cmd_byte          = CMD_WR | (eff_vcom ? CMD_VC : BYTE_ZERO);
               desc.slots[SLOT_CMD]   = (eff_byte == '0) && (eff_lit == '0);
               desc.slots[SLOT_ADDR]  = (eff_byte == '0);
               desc.slots[SLOT_PIX]   = 1'b1;
               desc.slots[SLOT_DUMMY] = line_done;
               desc.slots[SLOT_END]   = ends_txn;
               vcom_in = eff_vcom;
               if (line_done) begin
                  byte_in   = '0;
                  line_in   = line_inc;
                  rem_in    = rem_dec;
                  lit_in    = ends_txn ? '0 : lit_inc;
                  active_in = (rem_dec != '0);
               end else begin
                  byte_in   = eff_byte + 1'b1;
                  line_in   = eff_line;
                  rem_in    = eff_rem;
                  lit_in    = eff_lit;
                  active_in = 1'b1;
               end
            end
         end
         FUNC_TICK, FUNC_CLEAR: begin
            if (!active_ff) begin
               emits   = 1'b1;
               vcom_in = !vcom_ff;
               desc.cmd_byte = ((req_chan.func == FUNC_CLEAR) ? CMD_CLR : BYTE_ZERO)
                               | (!vcom_ff ? CMD_VC : BYTE_ZERO);
               desc.slots[SLOT_CMD] = 1'b1;
               desc.slots[SLOT_END] = 1'b1;
            end
         end
         default: begin
            emits = 1'b0;
         end
      endcase
   end

   assign push      = accept && emits;
   assign push_data = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcom_ff   <= 1'b0;
         active_ff <= 1'b0;
         line_ff   <= '0;
         rem_ff    <= '0;
         byte_ff   <= '0;
         lit_ff    <= '0;
         lpt_ff    <= LPT_RESET;
      end else begin
         if (accept) begin
            vcom_ff   <= vcom_in;
            active_ff <= active_in;
            line_ff   <= line_in;
            rem_ff    <= rem_in;
            byte_ff   <= byte_in;
            lit_ff    <= lit_in;
         end
         if (csr_chan.valid) begin
            lpt_ff <= csr_chan.data;
         end
      end
   end

   a_active_has_lines: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (rem_ff != '0))
      else $error("write active with no lines left");
   a_byte_in_range: assert property (@(posedge clock) disable iff (reset)
      byte_ff < BYTE_W'(LINE_BYTES))
      else $error("byte position past end of line");
   a_reject_alone: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.slots[SLOT_REJ]) |-> (push_data.slots[SLOT_END:SLOT_CMD] == '0))
      else $error("refused request carries data bytes");
   a_idle_after_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && !active_ff && req_chan.func != FUNC_PIXEL) |=> $stable(active_ff))
      else $error("tick or clear changed write state");

endmodule

// File: design/mlf_back.sv
module mlf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mlf_pkg::mlf_desc_type pop_data,
   input  logic                  empty,
   output logic                  pop,
   mlf_rsp_if.source             rsp_chan
);
   import mlf_pkg::*;

   mlf_desc_type      work_ff, work_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_eot_ff, rsp_eot_in;
   logic              rsp_ref_ff, rsp_ref_in;
   logic              out_free, work_empty, emit;
   logic [SLOT_N-1:0] low, rest;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_chan.ready;
      work_empty = (work_ff.slots == '0);
      emit       = out_free && !work_empty;
      low        = work_ff.slots & (~work_ff.slots + 1'b1);
      rest       = work_ff.slots & ~low;
      pop        = !empty && (work_empty || (emit && rest == '0));

      work_in = work_ff;
      if (pop) begin
         work_in = pop_data;
      end else if (emit) begin
         work_in.slots = rest;
      end

      rsp_byte_in  = BYTE_ZERO;
      rsp_eot_in   = 1'b0;
      rsp_ref_in   = 1'b0;
      if (low[SLOT_CMD]) begin
         rsp_byte_in = work_ff.cmd_byte;
      end else if (low[SLOT_ADDR]) begin
         rsp_byte_in = work_ff.addr_byte;
      end else if (low[SLOT_PIX]) begin
         rsp_byte_in = work_ff.pix_byte;
      end else if (low[SLOT_END]) begin
         rsp_eot_in = 1'b1;
      end else if (low[SLOT_REJ]) begin
         rsp_ref_in = 1'b1;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         work_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         work_ff      <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_eot_ff  <= rsp_eot_in;
         rsp_ref_ff  <= rsp_ref_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.out_byte           = rsp_byte_ff;
   assign rsp_chan.end_of_transaction = rsp_eot_ff;
   assign rsp_chan.refused            = rsp_ref_ff;

endmodule

// File: design/memory_lcd_line_framer_top.sv
// Memory-LCD line framer. Each request yields zero to five response bytes: a pixel byte
// gives one byte, plus the write command at a transaction start, the line address at a
// line start, and the dummy and closing bytes at a line or transaction end; VCOM-tick and
// clear give two while no write is active, else none. The front end takes a request
// every cycle while its four-entry descriptor queue has room; the back end sends one byte
// per cycle while the response channel is ready; the sustained rate is set by the number
// of bytes a request produces. lines_per_transaction is written through the csr channel,
// only while the framer is idle (user's rule, not enforced); a value of zero acts as one.
module memory_lcd_line_framer_top #(
   parameter int PANEL_LINES = 68,
   parameter int LINE_BYTES  = 20
) (
   input  logic      clock,
   input  logic      reset,
   mlf_req_if.sink   req_chan,
   mlf_rsp_if.source rsp_chan,
   mlf_csr_if.sink   csr_chan
);
   import mlf_pkg::*;

   logic         push, full, pop, empty;
   mlf_desc_type push_data, pop_data;

   mlf_front #(
      .PANEL_LINES (PANEL_LINES),
      .LINE_BYTES  (LINE_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   mlf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   mlf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_data (pop_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
